// File: rtl/front_to_back_ray_compositor_defines.svh
// assertion macros used by the checker file
`ifndef FRONT_TO_BACK_RAY_COMPOSITOR_DEFINES_SVH
`define FRONT_TO_BACK_RAY_COMPOSITOR_DEFINES_SVH

// property checked outside reset
`define FTB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ftb assertion failed");

// property checked at every edge, reset included
`define FTB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ftb assertion failed");

`endif

// File: rtl/ftb_pkg.sv
package ftb_pkg;

    // fixed point constants
    localparam logic [15:0] Q15_ONE      = 16'd32768;
    localparam logic [15:0] COLOR_MAX    = 16'hFFFF;
    localparam logic [31:0] ROUND_HALF   = 32'd16384;
    localparam logic [31:0] DEPTH_INF    = 32'h7F80_0000;
    localparam logic [15:0] RECIP_3      = 16'd43691;
    localparam int          RECIP_SHIFT  = 17;
    localparam logic [15:0] THRESH_RESET = 16'd32636;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_BLUE  = 2'd2;

    // input word: one shading hit
    typedef struct packed {
        logic [7:0]  ray_index;
        logic        first_hit;
        logic        miss;
        logic        matte;
        logic [15:0] ci_red;
        logic [15:0] ci_green;
        logic [15:0] ci_blue;
        logic [15:0] oi_red;
        logic [15:0] oi_green;
        logic [15:0] oi_blue;
        logic [31:0] hit_distance;
        logic        batch_end;
    } t_in_word;

    // output word: one sample result
    typedef struct packed {
        logic [7:0]  out_ray_index;
        logic        keep_tracing;
        logic        color_final;
        logic [15:0] sample_red;
        logic [15:0] sample_green;
        logic [15:0] sample_blue;
        logic [15:0] coverage;
        logic [31:0] depth_out;
        logic        depth_valid;
        logic        out_batch_end;
    } t_out_word;

    // per-ray table entry, channel 0 red, 1 green, 2 blue
    typedef struct packed {
        logic [2:0][15:0] col;
        logic [2:0][15:0] opa;
        logic [2:0][15:0] tr;
    } t_ray_entry;

    // opacity thresholds, same channel order
    typedef struct packed {
        logic [2:0][15:0] level;
    } t_thresh;

    // result before the coverage divide
    typedef struct packed {
        logic [7:0]       ray_index;
        logic             keep;
        logic             final_flag;
        logic [2:0][15:0] sample;
        logic [16:0]      opa_sum;
        logic [31:0]      depth;
        logic             depth_valid;
        logic             batch_end;
    } t_partial;

endpackage

// File: rtl/ftb_ray_table.sv
module ftb_ray_table
    import ftb_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_ray_entry        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_ray_entry        o_rd_data
);

    t_ray_entry mem [DEPTH];
    t_ray_entry r_rd_data;

    // one write port, one registered read port, read sees old data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/ftb_hit_update.sv
module ftb_hit_update
    import ftb_pkg::*;
(
    input  t_in_word   i_word,
    input  t_ray_entry i_old,
    input  t_thresh    i_thresh,
    output t_ray_entry o_new,
    output t_partial   o_part
);

    // per-channel compositing step
    always_comb begin
        logic [2:0][15:0] ci;
        logic [2:0][15:0] oi;
        logic [2:0][15:0] oi_c;
        logic [2:0][15:0] rem;
        logic [2:0][31:0] p_col;
        logic [2:0][31:0] p_opa;
        logic [2:0][31:0] p_tr;
        logic [2:0][16:0] m_col;
        logic [2:0][16:0] m_opa;
        logic [2:0][16:0] m_tr;
        logic [2:0][17:0] s_col;
        logic [2:0][17:0] s_opa;
        logic [2:0][15:0] hit_col;
        logic [2:0][15:0] hit_opa;
        logic [2:0][15:0] hit_tr;
        logic             transparent;
        logic             first_miss;

        ci = {i_word.ci_blue, i_word.ci_green, i_word.ci_red};
        oi = {i_word.oi_blue, i_word.oi_green, i_word.oi_red};
        transparent = 1'b0;

        for (int c = 0; c < 3; c++) begin
            // opacity above one counts as one
            oi_c[c] = (oi[c] > Q15_ONE) ? Q15_ONE : oi[c];
            rem[c]  = Q15_ONE - oi_c[c];
            transparent = transparent | (oi_c[c] < i_thresh.level[c]);

            // rounded q15 products against the stored transmission
            p_col[c] = 32'(ci[c]) * 32'(i_old.tr[c]) + ROUND_HALF;
            p_opa[c] = 32'(oi_c[c]) * 32'(i_old.tr[c]) + ROUND_HALF;
            p_tr[c]  = 32'(i_old.tr[c]) * 32'(rem[c]) + ROUND_HALF;
            m_col[c] = p_col[c][31:15];
            m_opa[c] = p_opa[c][31:15];
            m_tr[c]  = p_tr[c][31:15];

            // saturating accumulation
            s_col[c] = 18'(i_old.col[c]) + 18'(m_col[c]);
            s_opa[c] = 18'(i_old.opa[c]) + 18'(m_opa[c]);

            if (i_word.first_hit) begin
                hit_col[c] = i_word.matte ? 16'd0 : ci[c];
                hit_opa[c] = i_word.matte ? 16'd0 : oi_c[c];
                hit_tr[c]  = rem[c];
            end else begin
                if (i_word.matte) begin
                    hit_col[c] = i_old.col[c];
                    hit_opa[c] = i_old.opa[c];
                end else begin
                    hit_col[c] = (s_col[c] > 18'(COLOR_MAX)) ? COLOR_MAX : s_col[c][15:0];
                    hit_opa[c] = (s_opa[c] > 18'(Q15_ONE)) ? Q15_ONE : s_opa[c][15:0];
                end
                hit_tr[c] = (m_tr[c] > 17'(Q15_ONE)) ? Q15_ONE : m_tr[c][15:0];
            end
        end

        // a miss leaves the entry as it was
        if (i_word.miss) begin
            o_new = i_old;
        end else begin
            o_new.col = hit_col;
            o_new.opa = hit_opa;
            o_new.tr  = hit_tr;
        end

        first_miss = i_word.miss & i_word.first_hit;

        // result fields
        o_part.ray_index   = i_word.ray_index;
        o_part.keep        = ~i_word.miss & transparent;
        o_part.final_flag  = ~(~i_word.miss & transparent);
        o_part.sample      = first_miss ? '0 : o_new.col;
        // written opacities never exceed one, so the sum fits 17 bits
        o_part.opa_sum     = first_miss ? 17'd0 :
                             17'(o_new.opa[0]) + 17'(o_new.opa[1]) + 17'(o_new.opa[2]);
        o_part.depth       = !i_word.first_hit ? 32'd0 :
                             (i_word.miss ? DEPTH_INF : i_word.hit_distance);
        o_part.depth_valid = i_word.first_hit;
        o_part.batch_end   = i_word.batch_end;
    end

endmodule

// File: rtl/ftb_cov_stage.sv
module ftb_cov_stage
    import ftb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_partial  i_part,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    logic        r_valid;
    t_out_word   r_word;
    t_out_word   n_word;
    logic [16:0] sum_rnd;
    logic [32:0] cov_prod;

    assign o_ready = !r_valid || i_ready;

    // coverage = (sum + 1) / 3 by reciprocal multiply, exact below 2^17
    always_comb begin
        sum_rnd  = i_part.opa_sum + 17'd1;
        cov_prod = 33'(sum_rnd) * 33'(RECIP_3);

        n_word.out_ray_index = i_part.ray_index;
        n_word.keep_tracing  = i_part.keep;
        n_word.color_final   = i_part.final_flag;
        n_word.sample_red    = i_part.sample[0];
        n_word.sample_green  = i_part.sample[1];
        n_word.sample_blue   = i_part.sample[2];
        n_word.coverage      = 16'(cov_prod >> RECIP_SHIFT);
        n_word.depth_out     = i_part.depth;
        n_word.depth_valid   = i_part.depth_valid;
        n_word.out_batch_end = i_part.batch_end;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: rtl/front_to_back_ray_compositor.sv
// channel   direction  handshake                  word
// hit in    input      i_in_valid / o_in_ready    i_in_word  (t_in_word)
// sample    output     o_out_valid / i_out_ready  o_out_word (t_out_word)
// config    input      i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// one hit word is taken per cycle while o_in_ready is high; its sample passes
// the table read with the input register, compositing into the stage two
// register, and the coverage divide into the output register.
// the ray table read-modify-write sets the rate: a hit on the same ray in
// the next cycle is served from a bypass register, so no bubbles.
// synchronous active-low reset clears the stage valids, presets thresholds;
// the table needs no clearing pass, an entry is defined by its first hit.
// a stalled output lets the three stages fill, then drops o_in_ready.
module front_to_back_ray_compositor
    import ftb_pkg::*;
#(
    parameter int RAY_SLOTS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word
);

    localparam int SLOT_W = (RAY_SLOTS > 1) ? $clog2(RAY_SLOTS) : 1;

    t_thresh     r_thresh;
    logic        r_s1_valid;
    t_in_word    r_s1_word;
    logic [SLOT_W-1:0] r_s1_slot;
    logic        r_fwd_valid;
    t_ray_entry  r_fwd_entry;
    logic        r_s2_valid;
    t_partial    r_s2_part;

    logic [SLOT_W-1:0] slot_lut [256];
    logic [SLOT_W-1:0] in_slot;
    logic        in_accept;
    logic        s1_adv;
    logic        s2_ready;
    logic        s2_adv;
    logic        cov_ready;
    t_ray_entry  rd_entry;
    t_ray_entry  old_entry;
    t_ray_entry  new_entry;
    t_partial    s1_part;

    // ray index to table slot, modulo worked out at elaboration
    for (genvar g = 0; g < 256; g++) begin : g_slot
        assign slot_lut[g] = SLOT_W'(g % RAY_SLOTS);
    end
    assign in_slot = slot_lut[i_in_word.ray_index];

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.level <= {THRESH_RESET, THRESH_RESET, THRESH_RESET};
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_THR_RED:   r_thresh.level[0] <= i_cfg_data;
                CFG_THR_GREEN: r_thresh.level[1] <= i_cfg_data;
                CFG_THR_BLUE:  r_thresh.level[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage handshakes
    assign s2_adv     = r_s2_valid && cov_ready;
    assign s2_ready   = !r_s2_valid || cov_ready;
    assign s1_adv     = r_s1_valid && s2_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    // ray table, written when a hit leaves stage one
    ftb_ray_table #(
        .DEPTH  (RAY_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_slot),
        .i_wr_data (new_entry),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_slot),
        .o_rd_data (rd_entry)
    );

    // stage one register and same-ray bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (in_accept) begin
                r_fwd_valid <= s1_adv && (r_s1_slot == in_slot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_word   <= i_in_word;
            r_s1_slot   <= in_slot;
            r_fwd_entry <= new_entry;
        end
    end

    assign old_entry = r_fwd_valid ? r_fwd_entry : rd_entry;

    // compositing
    ftb_hit_update u_update (
        .i_word   (r_s1_word),
        .i_old    (old_entry),
        .i_thresh (r_thresh),
        .o_new    (new_entry),
        .o_part   (s1_part)
    );

    // stage two register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_part <= s1_part;
        end
    end

    // coverage and output register
    ftb_cov_stage u_cov (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_adv),
        .o_ready (cov_ready),
        .i_part  (r_s2_part),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

// File: rtl/ftb_checker.sv
`include "front_to_back_ray_compositor_defines.svh"

module ftb_checker
    import ftb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // no sample comes out right after reset
    `FTB_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid)

    // a waiting hit word holds until taken
    `FTB_ASSERT(a_in_hold, i_clk, i_rst_n,
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_word))

    // a stalled sample word holds
    `FTB_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))

    // a sample is either final or still tracing, never both
    `FTB_ASSERT(a_final_xor_keep, i_clk, i_rst_n,
        o_out_valid |-> o_out_word.color_final != o_out_word.keep_tracing)

    // depth is only driven when it updates the sample
    `FTB_ASSERT(a_depth_quiet, i_clk, i_rst_n,
        o_out_valid && !o_out_word.depth_valid |-> o_out_word.depth_out == 32'd0)

endmodule

bind front_to_back_ray_compositor ftb_checker u_ftb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
